[rtl/plst_pkg.sv]
`default_nettype none
package plst_pkg;

    localparam int CAPACITY = 16;
    localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int LEN_W    = $clog2(CAPACITY + 1);

    localparam int ACTION_W = 2;
    localparam int POS_W    = 5;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    localparam int CMP_W = ((LEN_W > POS_W) ? LEN_W : POS_W) + 1;

    localparam int IN_W       = ACTION_W + POS_W + VALUE_W;
    localparam int IN_TDATA_W = ((IN_W + 7) / 8) * 8;
    localparam int IN_ACT_LSB = 0;
    localparam int IN_POS_LSB = ACTION_W;
    localparam int IN_VAL_LSB = ACTION_W + POS_W;

    localparam int OUT_W        = STATUS_W + VALUE_W + COUNT_W;
    localparam int OUT_TDATA_W  = ((OUT_W + 7) / 8) * 8;
    localparam int OUT_PAD_W    = OUT_TDATA_W - OUT_W;

    localparam logic [ACTION_W-1:0] ACT_INSERT = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_DELETE = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_READ   = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic                we;
        logic [ADDR_W-1:0]   waddr;
        logic [VALUE_W-1:0]  wdata;
        logic                re;
        logic [ADDR_W-1:0]   raddr;
    } mem_req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [VALUE_W-1:0]  read_value;
        logic [COUNT_W-1:0]  count;
    } result_t;

endpackage
`default_nettype wire

[rtl/plst_ram.sv]
`default_nettype none
module plst_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                                     clk,
    input  wire logic                                     we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                         wdata,
    input  wire logic                                     re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

[rtl/plst_ctrl.sv]
`default_nettype none
module plst_ctrl (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire logic [plst_pkg::ACTION_W-1:0]   action,
    input  wire logic [plst_pkg::POS_W-1:0]      position,
    input  wire logic [plst_pkg::VALUE_W-1:0]    value,
    output logic                                 res_valid,
    input  wire logic                            res_ready,
    output plst_pkg::result_t                    res,
    output plst_pkg::mem_req_t                   mem_req,
    input  wire logic [plst_pkg::VALUE_W-1:0]    rdata
);
    import plst_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MOVE,
        S_FIN
    } state_t;

    state_t              state_reg, state_next;
    logic [LEN_W-1:0]    len_reg, len_next;
    logic [LEN_W-1:0]    cnt_reg, cnt_next;
    logic [ADDR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [ADDR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic                up_reg, up_next;
    logic                first_reg, first_next;
    logic                pend_reg, pend_next;
    logic                fin_we_reg, fin_we_next;
    logic [ADDR_W-1:0]   fin_addr_reg, fin_addr_next;
    logic [VALUE_W-1:0]  fin_data_reg, fin_data_next;
    logic [LEN_W-1:0]    len_fin_reg, len_fin_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [VALUE_W-1:0]  rval_reg, rval_next;

    logic [CMP_W-1:0]    pos_ext;
    logic [CMP_W-1:0]    len_ext;
    logic [CMP_W-1:0]    idx_ext;
    logic [CMP_W-1:0]    span_ext;
    logic [ADDR_W-1:0]   idx;
    logic [ADDR_W-1:0]   len_addr;
    logic                pos_ok_ins;
    logic                pos_ok_acc;
    logic                full;

    assign pos_ext    = CMP_W'(position);
    assign len_ext    = CMP_W'(len_reg);
    assign idx_ext    = pos_ext - CMP_W'(1);
    assign span_ext   = len_ext - idx_ext;
    assign idx        = idx_ext[ADDR_W-1:0];
    assign len_addr   = len_ext[ADDR_W-1:0];
    assign pos_ok_ins = (pos_ext != '0) && (pos_ext <= len_ext + CMP_W'(1));
    assign pos_ok_acc = (pos_ext != '0) && (pos_ext <= len_ext);
    assign full       = (len_ext >= CMP_W'(CAPACITY));

    assign in_ready  = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_FIN);
    assign res.status     = status_reg;
    assign res.read_value = rval_reg;
    assign res.count      = COUNT_W'(CMP_W'(len_fin_reg));

    always_comb
    begin
        state_next    = state_reg;
        len_next      = len_reg;
        cnt_next      = cnt_reg;
        rd_ptr_next   = rd_ptr_reg;
        wr_ptr_next   = wr_ptr_reg;
        up_next       = up_reg;
        first_next    = first_reg;
        pend_next     = 1'b0;
        fin_we_next   = fin_we_reg;
        fin_addr_next = fin_addr_reg;
        fin_data_next = fin_data_reg;
        len_fin_next  = len_fin_reg;
        status_next   = status_reg;
        rval_next     = rval_reg;
        mem_req.we    = 1'b0;
        mem_req.waddr = wr_ptr_reg;
        mem_req.wdata = rdata;
        mem_req.re    = 1'b0;
        mem_req.raddr = rd_ptr_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    first_next   = 1'b0;
                    fin_we_next  = 1'b0;
                    len_fin_next = len_reg;
                    rval_next    = '0;
                    status_next  = ST_RANGE;
                    state_next   = S_FIN;
                    priority if (action == ACT_INSERT && pos_ok_ins && !full)
                    begin
                        status_next   = ST_OK;
                        cnt_next      = LEN_W'(span_ext);
                        rd_ptr_next   = len_addr - ADDR_W'(1);
                        wr_ptr_next   = len_addr;
                        up_next       = 1'b0;
                        fin_we_next   = 1'b1;
                        fin_addr_next = idx;
                        fin_data_next = value;
                        len_fin_next  = len_reg + LEN_W'(1);
                        state_next    = S_MOVE;
                    end
                    else if (action == ACT_INSERT && pos_ok_ins)
                    begin
                        status_next = ST_FULL;
                    end
                    else if (action == ACT_DELETE && pos_ok_acc)
                    begin
                        status_next   = ST_OK;
                        cnt_next      = LEN_W'(span_ext);
                        rd_ptr_next   = idx;
                        wr_ptr_next   = idx - ADDR_W'(1);
                        up_next       = 1'b1;
                        first_next    = 1'b1;
                        fin_we_next   = 1'b1;
                        fin_addr_next = len_addr - ADDR_W'(1);
                        fin_data_next = '0;
                        len_fin_next  = len_reg - LEN_W'(1);
                        state_next    = S_MOVE;
                    end
                    else if (action == ACT_READ && pos_ok_acc)
                    begin
                        status_next = ST_OK;
                        cnt_next    = LEN_W'(1);
                        rd_ptr_next = idx;
                        up_next     = 1'b1;
                        first_next  = 1'b1;
                        state_next  = S_MOVE;
                    end
                    else
                    begin
                        status_next = ST_RANGE;
                    end
                end
            end
            S_MOVE:
            begin
                if (pend_reg)
                begin
                    if (first_reg)
                    begin
                        rval_next  = rdata;
                        first_next = 1'b0;
                    end
                    else
                    begin
                        mem_req.we = 1'b1;
                    end
                    wr_ptr_next = up_reg ? wr_ptr_reg + ADDR_W'(1)
                                         : wr_ptr_reg - ADDR_W'(1);
                end
                if (cnt_reg != '0)
                begin
                    mem_req.re  = 1'b1;
                    pend_next   = 1'b1;
                    cnt_next    = cnt_reg - LEN_W'(1);
                    rd_ptr_next = up_reg ? rd_ptr_reg + ADDR_W'(1)
                                         : rd_ptr_reg - ADDR_W'(1);
                end
                else if (!pend_reg)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (res_ready)
                begin
                    mem_req.we    = fin_we_reg;
                    mem_req.waddr = fin_addr_reg;
                    mem_req.wdata = fin_data_reg;
                    len_next      = len_fin_reg;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            len_reg      <= '0;
            cnt_reg      <= '0;
            pend_reg     <= 1'b0;
            first_reg    <= 1'b0;
            fin_we_reg   <= 1'b0;
            rd_ptr_reg   <= '0;
            wr_ptr_reg   <= '0;
            up_reg       <= 1'b0;
            fin_addr_reg <= '0;
            fin_data_reg <= '0;
            len_fin_reg  <= '0;
            status_reg   <= ST_OK;
            rval_reg     <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            len_reg      <= len_next;
            cnt_reg      <= cnt_next;
            pend_reg     <= pend_next;
            first_reg    <= first_next;
            fin_we_reg   <= fin_we_next;
            rd_ptr_reg   <= rd_ptr_next;
            wr_ptr_reg   <= wr_ptr_next;
            up_reg       <= up_next;
            fin_addr_reg <= fin_addr_next;
            fin_data_reg <= fin_data_next;
            len_fin_reg  <= len_fin_next;
            status_reg   <= status_next;
            rval_reg     <= rval_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_len_cap: assert property (@(posedge clk) disable iff (!rst_n)
        CMP_W'(len_reg) <= CMP_W'(CAPACITY))
        else $error("list length above capacity");

    a_pend_move: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> state_reg == S_MOVE)
        else $error("read outstanding outside shift");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> state_reg != S_IDLE)
        else $error("transaction accepted without leaving idle");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && status_reg != ST_OK |-> rval_reg == '0)
        else $error("failed transaction returns nonzero value");
`endif

endmodule
`default_nettype wire

[rtl/positional_list_store.sv]
// Positional list store: an ordered list of signed 32-bit values held in a
// single-port-write, single-port-read RAM of plst_pkg::CAPACITY entries.
// Slave stream (s_axis_*) carries one operation per transaction: insert,
// delete or read at a 1-based position. Master stream (m_axis_*) returns
// exactly one result per operation: status, read value and list length.
// An operation that moves n entries (n = length - position + 1 for insert
// and delete, n = 1 for read) passes through the controller's move state
// and result state; the result enters the output register, which drives
// m_axis_tvalid, as the controller returns to idle and raises s_axis_tready.
// An insert at the end of the list moves no entry, and a rejected operation
// skips the move state. The RAM moves one entry per cycle, so a worst-case
// delete from a full store moves CAPACITY entries.
// One operation is in progress at a time; the next one is accepted once the
// result leaves the controller, even while the result register still waits.
// When the receiver stalls, the result is held in the output register and a
// finished operation waits for it to drain before committing.
// Reset clears the length to zero; the list then reads as empty and no RAM
// entry is visible until written.
`default_nettype none
module positional_list_store (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    // action[1:0], position[6:2], value[38:7], zero pad
    input  wire logic [plst_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    // status[1:0], read_value[33:2], count[38:34], zero pad
    output logic      [plst_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);
    import plst_pkg::*;

    logic                res_valid;
    logic                res_ready;
    result_t             res;
    mem_req_t            mem_req;
    logic [VALUE_W-1:0]  rdata;

    logic                out_valid_reg;
    result_t             out_data_reg;

    plst_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .action    (s_axis_tdata[IN_ACT_LSB +: ACTION_W]),
        .position  (s_axis_tdata[IN_POS_LSB +: POS_W]),
        .value     (s_axis_tdata[IN_VAL_LSB +: VALUE_W]),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .mem_req   (mem_req),
        .rdata     (rdata)
    );

    plst_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk   (clk),
        .we    (mem_req.we),
        .waddr (mem_req.waddr),
        .wdata (mem_req.wdata),
        .re    (mem_req.re),
        .raddr (mem_req.raddr),
        .rdata (rdata)
    );

    assign res_ready = !out_valid_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            out_data_reg <= res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, out_data_reg.count,
                            out_data_reg.read_value, out_data_reg.status};

endmodule
`default_nettype wire
